[hdl/argh_pkg.sv]
// Package for the AES-round glyph hash block: codes, register indexes and the
// inverse AES round helpers used by the top level. Depends on nothing.

package argh_pkg;

   // Number of AES decryption rounds applied to each 16-byte block.
   localparam int ROUNDS_PER_BLOCK = 4;

   // Field widths.
   localparam int HASH_W   = 128;
   localparam int HALF_W   = 64;
   localparam int SEED_W   = 32;
   localparam int LEN_W    = 16;
   localparam int TILE_W   = 16;
   localparam int VBYTES_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int BLOCK_BYTES = 16;

   // Request commands.
   localparam logic CMD_CHUNK = 1'b0;
   localparam logic CMD_TILE  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SEED0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED3 = 2'd3;

   // Seed values after reset.
   localparam logic [SEED_W-1:0] SEED0_RESET = 32'd4032809394;
   localparam logic [SEED_W-1:0] SEED1_RESET = 32'd3633260840;
   localparam logic [SEED_W-1:0] SEED2_RESET = 32'd1924321538;
   localparam logic [SEED_W-1:0] SEED3_RESET = 32'd3165652200;

   typedef logic [HASH_W-1:0] hash_type;

   // AES inverse S-box.
   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
      8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
      8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
      8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
      8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
      8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
      8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
      8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
      8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
      8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
      8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
      8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
      8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
      8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
      8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
      8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
      8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
      8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
      8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
      8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
      8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
      8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
      8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
      8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
      8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
      8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
      8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
      8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
      8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
      8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
      8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
      8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
   };

   // Multiply by x in GF(2^8) with the AES polynomial.
   function automatic logic [7:0] xtime(input logic [7:0] a);
      return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
   endfunction

   // Column coefficients of InvMixColumns, built from x2, x4 and x8.
   function automatic logic [7:0] mul9(input logic [7:0] a);
      logic [7:0] a8;
      a8 = xtime(xtime(xtime(a)));
      return a8 ^ a;
   endfunction

   function automatic logic [7:0] mul11(input logic [7:0] a);
      logic [7:0] a2;
      logic [7:0] a8;
      a2 = xtime(a);
      a8 = xtime(xtime(a2));
      return a8 ^ a2 ^ a;
   endfunction

   function automatic logic [7:0] mul13(input logic [7:0] a);
      logic [7:0] a4;
      logic [7:0] a8;
      a4 = xtime(xtime(a));
      a8 = xtime(a4);
      return a8 ^ a4 ^ a;
   endfunction

   function automatic logic [7:0] mul14(input logic [7:0] a);
      logic [7:0] a2;
      logic [7:0] a4;
      logic [7:0] a8;
      a2 = xtime(a);
      a4 = xtime(a2);
      a8 = xtime(a4);
      return a8 ^ a4 ^ a2;
   endfunction

   // One AES decryption round with a zero round key: InvShiftRows,
   // InvSubBytes and InvMixColumns. Byte i sits at bits 8i+7..8i.
   function automatic hash_type dec_round(input hash_type h);
      logic [7:0] s [BLOCK_BYTES];
      logic [7:0] t [BLOCK_BYTES];
      hash_type   res;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         s[i] = h[8*i +: 8];
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[r + 4*c] = INV_SBOX[s[r + 4*((c - r + 4) & 3)]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         res[8*(4*c) +: 8]     = mul14(t[4*c]) ^ mul11(t[4*c+1]) ^
                                 mul13(t[4*c+2]) ^ mul9(t[4*c+3]);
         res[8*(4*c+1) +: 8]   = mul9(t[4*c]) ^ mul14(t[4*c+1]) ^
                                 mul11(t[4*c+2]) ^ mul13(t[4*c+3]);
         res[8*(4*c+2) +: 8]   = mul13(t[4*c]) ^ mul9(t[4*c+1]) ^
                                 mul14(t[4*c+2]) ^ mul11(t[4*c+3]);
         res[8*(4*c+3) +: 8]   = mul11(t[4*c]) ^ mul13(t[4*c+1]) ^
                                 mul9(t[4*c+2]) ^ mul14(t[4*c+3]);
      end
      return res;
   endfunction

   // The fixed chain of decryption rounds applied to each block.
   function automatic hash_type mix_rounds(input hash_type h);
      hash_type v;
      v = h;
      for (int k = 0; k < ROUNDS_PER_BLOCK; k++) begin
         v = dec_round(v);
      end
      return v;
   endfunction

   // Keep the leading n bytes of a block; counts above 16 keep all.
   function automatic hash_type byte_mask(input logic [VBYTES_W-1:0] n);
      hash_type m;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         m[8*i +: 8] = (VBYTES_W'(i) < n) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

[hdl/aes_round_glyph_hash.sv]
// Top level of the AES-round glyph hash: request register, round logic,
// running and kept hash, seed registers and result register.
// Depends on argh_pkg.

// Channel  Direction  Handshake              Payload
// req_     in         req_valid / req_stall  command, first_chunk, total_length,
//                                            data_low, data_high, valid_bytes,
//                                            last_chunk, tile_index
// rsp_     out        rsp_valid / rsp_stall  hash_low, hash_high, from_tile
// csr_     in         csr_valid / csr_ready  csr_index, csr_data (seed words)
//
// The block takes one request per clock cycle unless the result side stalls. A
// request is held in the request register; its result, if any, is loaded from
// there into the result register, which drives rsp_valid, and the result is
// taken from the result register.
// The four decryption rounds lie between those registers: each
// chunk needs the running hash left by the previous one, and the round logic
// produces it within the cycle. Synchronous reset empties both registers,
// clears the running and kept hash and restores the seed words. A stall on the
// result side holds the result register, and the request register then stalls
// the request side in the same cycle.

module aes_round_glyph_hash (
   input  logic                             clock,
   input  logic                             reset,
   // Requests.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic                             req_first_chunk,
   input  logic [argh_pkg::LEN_W-1:0]       req_total_length,
   input  logic [argh_pkg::HALF_W-1:0]      req_data_low,
   input  logic [argh_pkg::HALF_W-1:0]      req_data_high,
   input  logic [argh_pkg::VBYTES_W-1:0]    req_valid_bytes,
   input  logic                             req_last_chunk,
   input  logic [argh_pkg::TILE_W-1:0]      req_tile_index,
   // Results.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [argh_pkg::HALF_W-1:0]      rsp_hash_low,
   output logic [argh_pkg::HALF_W-1:0]      rsp_hash_high,
   output logic                             rsp_from_tile,
   // Configuration writes.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [argh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [argh_pkg::SEED_W-1:0]      csr_data
);

   // Request register.
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic                            s1_command_ff;
   logic                            s1_first_ff;
   logic [argh_pkg::LEN_W-1:0]      s1_length_ff;
   logic [argh_pkg::HASH_W-1:0]     s1_data_ff;
   logic [argh_pkg::VBYTES_W-1:0]   s1_vbytes_ff;
   logic                            s1_last_ff;
   logic [argh_pkg::TILE_W-1:0]     s1_tile_ff;

   // Hash state and seeds.
   argh_pkg::hash_type              running_ff;
   argh_pkg::hash_type              running_in;
   argh_pkg::hash_type              kept_ff;
   argh_pkg::hash_type              kept_in;
   logic [argh_pkg::SEED_W-1:0]     seed0_ff;
   logic [argh_pkg::SEED_W-1:0]     seed1_ff;
   logic [argh_pkg::SEED_W-1:0]     seed2_ff;
   logic [argh_pkg::SEED_W-1:0]     seed3_ff;

   // Result register.
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   argh_pkg::hash_type              rsp_hash_ff;
   argh_pkg::hash_type              rsp_hash_in;
   logic                            rsp_tile_ff;

   // Datapath.
   logic                            out_free;
   logic                            advance;
   logic                            has_result;
   logic                            is_tile;
   argh_pkg::hash_type              chunk_base;
   argh_pkg::hash_type              tile_rep;
   argh_pkg::hash_type              mix_in;
   argh_pkg::hash_type              mix_out;

   // The result register can take a new value when it is empty or being read.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   assign is_tile    = (s1_command_ff == argh_pkg::CMD_TILE);
   assign has_result = is_tile || s1_last_ff;

   // A new string starts from the length in the low word, XORed with the seed.
   // Otherwise hashing continues from the running hash as it stands.
   assign chunk_base = s1_first_ff ?
      {seed3_ff, seed2_ff, seed1_ff,
       seed0_ff ^ {{(argh_pkg::SEED_W - argh_pkg::LEN_W){1'b0}}, s1_length_ff}} :
      running_ff;

   // The tile number fills all four 32-bit lanes.
   assign tile_rep = {4{{(argh_pkg::SEED_W - argh_pkg::TILE_W){1'b0}}, s1_tile_ff}};

   // One round unit serves both commands.
   assign mix_in  = is_tile ? (kept_ff ^ tile_rep)
                            : (chunk_base ^ (s1_data_ff & argh_pkg::byte_mask(s1_vbytes_ff)));
   assign mix_out = argh_pkg::mix_rounds(mix_in);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      running_in   = running_ff;
      kept_in      = kept_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
      if (advance && !is_tile) begin
         running_in = mix_out;
         if (s1_last_ff) begin
            kept_in = mix_out;
         end
      end
      if (out_free) begin
         rsp_valid_in = advance && has_result;
      end
      // Tile index zero hands back the kept hash untouched.
      if (is_tile && (s1_tile_ff == '0)) begin
         rsp_hash_in = kept_ff;
      end else begin
         rsp_hash_in = mix_out;
      end
   end

   // Control state and hash state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         running_ff   <= '0;
         kept_ff      <= '0;
         seed0_ff     <= argh_pkg::SEED0_RESET;
         seed1_ff     <= argh_pkg::SEED1_RESET;
         seed2_ff     <= argh_pkg::SEED2_RESET;
         seed3_ff     <= argh_pkg::SEED3_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
         kept_ff      <= kept_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               argh_pkg::CSR_SEED0: seed0_ff <= csr_data;
               argh_pkg::CSR_SEED1: seed1_ff <= csr_data;
               argh_pkg::CSR_SEED2: seed2_ff <= csr_data;
               argh_pkg::CSR_SEED3: seed3_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_command_ff <= req_command;
         s1_first_ff   <= req_first_chunk;
         s1_length_ff  <= req_total_length;
         s1_data_ff    <= {req_data_high, req_data_low};
         s1_vbytes_ff  <= req_valid_bytes;
         s1_last_ff    <= req_last_chunk;
         s1_tile_ff    <= req_tile_index;
      end
      if (advance && has_result) begin
         rsp_hash_ff <= rsp_hash_in;
         rsp_tile_ff <= is_tile;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hash_low  = rsp_hash_ff[argh_pkg::HALF_W-1:0];
   assign rsp_hash_high = rsp_hash_ff[argh_pkg::HASH_W-1:argh_pkg::HALF_W];
   assign rsp_from_tile = rsp_tile_ff;

   // The request side stalls only while a request waits behind a held result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stall without a held result");

   // A tile request leaves the running and kept hash alone.
   assert property (@(posedge clock) disable iff (reset)
      (advance && is_tile) |=> ($stable(running_ff) && $stable(kept_ff)))
      else $error("tile request changed the hash state");

   // A last chunk shows the hash it keeps, marked as a string hash.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !is_tile && s1_last_ff) |=>
         (rsp_valid_ff && !rsp_tile_ff && (rsp_hash_ff == kept_ff)))
      else $error("string result differs from the kept hash");

   // A chunk that is not last produces no new result.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !is_tile && !s1_last_ff) |=> !rsp_valid_ff)
      else $error("result produced for an inner chunk");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for aes_round_glyph_hash: directed rows, then seeded
// phases of random strings, tile requests and noise, scored against an in-bench
// hash predictor or typed-in expectations. Depends on argh_pkg and the RTL top.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Run shape. A phase is one seed setting followed by its random requests.
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 175;
   // A result is loaded into the result register from the request register; the
   // settle time covers a chunk that is still in flight without making a result.
   localparam int SETTLE_CYCLES = 6;
   // Longest legal stretch without any handshake is a sender gap plus a
   // receiver stall plus latency.
   localparam int STALL_LIMIT   = 2000;
   localparam int PRINT_CAP     = 40;

   // One result of the block, in the order of the result ports.
   typedef struct packed {
      bit [argh_pkg::HALF_W-1:0] hash_low;
      bit [argh_pkg::HALF_W-1:0] hash_high;
      bit                        from_tile;
   } hash_result_type;

   // One request plus an optional hand-written expectation for it.
   typedef struct packed {
      bit                          cmd;
      bit                          first;
      bit                          last;
      bit [argh_pkg::VBYTES_W-1:0] vbytes;
      bit [argh_pkg::LEN_W-1:0]    total;
      bit [argh_pkg::TILE_W-1:0]   tile;
      bit [argh_pkg::HALF_W-1:0]   dlo;
      bit [argh_pkg::HALF_W-1:0]   dhi;
      bit                          given;
      hash_result_type             want;
   } hash_request_type;

   localparam hash_result_type UNSET = '0;
   localparam hash_result_type ZERO_TILE_HASH = '{64'h0, 64'h0, 1'b1};
   localparam bit [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
   localparam bit [63:0] BYTES_LO = 64'h0706_0504_0302_0100;
   localparam bit [63:0] BYTES_HI = 64'h0f0e_0d0c_0b0a_0908;
   localparam bit [63:0] MIXED_LO = 64'hdead_beef_0123_4567;
   localparam bit [63:0] MIXED_HI = 64'h89ab_cdef_f00d_cafe;

   // InvMixColumns row coefficients; row k uses them rotated right by k.
   localparam bit [7:0] INV_MIX [4] = '{8'd14, 8'd11, 8'd13, 8'd9};

   localparam logic [argh_pkg::CSR_IDX_W-1:0] SEED_REGS [4] =
      '{argh_pkg::CSR_SEED0, argh_pkg::CSR_SEED1, argh_pkg::CSR_SEED2, argh_pkg::CSR_SEED3};

   // Directed rows. Only the rows whose answer is obvious carry a typed-in
   // expectation; everything else is scored by the predictor.
   localparam int DIRECTED_COUNT = 21;
   localparam hash_request_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Straight out of reset the kept hash is zero, so tile zero reads zero.
      '{argh_pkg::CMD_TILE,  1'b0, 1'b0, 5'd0,  16'd0,      16'd0,
        64'h0, 64'h0, 1'b1, ZERO_TILE_HASH},
      // Tile request before any string has been hashed.
      '{argh_pkg::CMD_TILE,  1'b0, 1'b0, 5'd0,  16'd0,      16'd1,
        64'h0, 64'h0, 1'b0, UNSET},
      // Chunk with no start, not last: hashes on from zero, no result.
      '{argh_pkg::CMD_CHUNK, 1'b0, 1'b0, 5'd5,  16'd0,      16'd0,
        ALL_ONES, ALL_ONES, 1'b0, UNSET},
      // Nothing was kept yet, so tile zero still reads zero.
      '{argh_pkg::CMD_TILE,  1'b0, 1'b0, 5'd0,  16'd0,      16'd0,
        64'h0, 64'h0, 1'b1, ZERO_TILE_HASH},
      '{argh_pkg::CMD_CHUNK, 1'b0, 1'b1, 5'd16, 16'd0,      16'd0,
        BYTES_LO, BYTES_HI, 1'b0, UNSET},
      // Empty string: the rounds still run, on the seed block with no data bytes.
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b1, 5'd0,  16'd0,      16'd0,
        ALL_ONES, ALL_ONES, 1'b0, UNSET},
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b1, 5'd16, 16'hffff,   16'd0,
        ALL_ONES, ALL_ONES, 1'b0, UNSET},
      // Byte counts above sixteen behave as sixteen.
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b0, 5'd31, 16'd40,     16'd0,
        MIXED_LO, MIXED_HI, 1'b0, UNSET},
      '{argh_pkg::CMD_CHUNK, 1'b0, 1'b0, 5'd17, 16'd0,      16'd0,
        BYTES_LO, MIXED_HI, 1'b0, UNSET},
      '{argh_pkg::CMD_CHUNK, 1'b0, 1'b1, 5'd8,  16'd0,      16'd0,
        MIXED_LO, ALL_ONES, 1'b0, UNSET},
      // Tile zero returns the kept string hash.
      '{argh_pkg::CMD_TILE,  1'b0, 1'b0, 5'd0,  16'd0,      16'd0,
        64'h0, 64'h0, 1'b0, UNSET},
      '{argh_pkg::CMD_TILE,  1'b0, 1'b0, 5'd0,  16'd0,      16'hffff,
        64'h0, 64'h0, 1'b0, UNSET},
      // A tile request ignores the start, last and data fields.
      '{argh_pkg::CMD_TILE,  1'b1, 1'b1, 5'd16, 16'hffff,   16'h1234,
        ALL_ONES, ALL_ONES, 1'b0, UNSET},
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b1, 5'd1,  16'd1,      16'd0,
        ALL_ONES, ALL_ONES, 1'b0, UNSET},
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b1, 5'd9,  16'd9,      16'd0,
        ALL_ONES, ALL_ONES, 1'b0, UNSET},
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b0, 5'd15, 16'd15,     16'd0,
        MIXED_LO, MIXED_HI, 1'b0, UNSET},
      // A new start in the middle of a string drops the partial hash.
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b1, 5'd7,  16'd7,      16'd0,
        BYTES_LO, BYTES_HI, 1'b0, UNSET},
      '{argh_pkg::CMD_CHUNK, 1'b1, 1'b1, 5'd16, 16'd16,     16'd0,
        64'h0, 64'h0, 1'b0, UNSET},
      // Without a start the length field is not read.
      '{argh_pkg::CMD_CHUNK, 1'b0, 1'b1, 5'd0,  16'hffff,   16'hffff,
        64'h0, 64'h0, 1'b0, UNSET},
      '{argh_pkg::CMD_TILE,  1'b0, 1'b0, 5'd0,  16'd0,      16'h8000,
        64'h0, 64'h0, 1'b0, UNSET},
      '{argh_pkg::CMD_TILE,  1'b0, 1'b0, 5'd0,  16'd0,      16'd0,
        64'h0, 64'h0, 1'b0, UNSET}
   };

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_command;
   logic                           req_first_chunk;
   logic [argh_pkg::LEN_W-1:0]     req_total_length;
   logic [argh_pkg::HALF_W-1:0]    req_data_low;
   logic [argh_pkg::HALF_W-1:0]    req_data_high;
   logic [argh_pkg::VBYTES_W-1:0]  req_valid_bytes;
   logic                           req_last_chunk;
   logic [argh_pkg::TILE_W-1:0]    req_tile_index;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [argh_pkg::HALF_W-1:0]    rsp_hash_low;
   logic [argh_pkg::HALF_W-1:0]    rsp_hash_high;
   logic                           rsp_from_tile;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [argh_pkg::CSR_IDX_W-1:0] csr_index;
   logic [argh_pkg::SEED_W-1:0]    csr_data;

   // Sideband that travels with each request: a typed-in expectation, if any.
   logic                           row_given;
   hash_result_type                row_want;

   // Predictor state: its own copy of the seed, running hash and kept hash.
   bit [7:0]                       inv_sub_lut [256];
   bit [argh_pkg::HASH_W-1:0]      seed_state;
   bit [argh_pkg::HASH_W-1:0]      run_state;
   bit [argh_pkg::HASH_W-1:0]      kept_state;
   hash_result_type                pending_hashes [$];

   int unsigned          error_count = 0;
   int unsigned          idle_cycles = 0;
   int unsigned          items_sent = 0;
   int unsigned          chunk_count = 0;
   int unsigned          tile_count = 0;
   int unsigned          checked_count = 0;
   int unsigned          stall_left = 0;
   int unsigned          free_left = 0;
   bit                   quiet_tail = 1'b0;

   always #4 clock = ~clock;

   aes_round_glyph_hash dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_first_chunk  (req_first_chunk),
      .req_total_length (req_total_length),
      .req_data_low     (req_data_low),
      .req_data_high    (req_data_high),
      .req_valid_bytes  (req_valid_bytes),
      .req_last_chunk   (req_last_chunk),
      .req_tile_index   (req_tile_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_low     (rsp_hash_low),
      .rsp_hash_high    (rsp_hash_high),
      .rsp_from_tile    (rsp_from_tile),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ---------------------------------------------------------------------
   // Hash predictor
   // ---------------------------------------------------------------------

   // Product in GF(2^8) under the AES polynomial, by shift and add.
   function automatic bit [7:0] gf_times(input bit [7:0] a, input bit [7:0] b);
      bit [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) acc ^= a;
         a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
         b = b >> 1;
      end
      return acc;
   endfunction

   // Inverse S-box entry, computed rather than looked up: undo the affine
   // map, then raise to the power 254 to get the field inverse.
   function automatic bit [7:0] inv_sub_byte(input bit [7:0] x);
      bit [7:0] y;
      bit [7:0] sq;
      bit [7:0] acc;
      y = {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05;
      sq = y;
      acc = 8'h01;
      for (int i = 1; i < 8; i++) begin
         sq = gf_times(sq, sq);
         acc = gf_times(acc, sq);
      end
      return acc;
   endfunction

   // One decryption round with a zero key. Byte i sits at bits 8i+7..8i,
   // byte r + 4c being row r of column c.
   function automatic bit [argh_pkg::HASH_W-1:0] aes_dec_round(
      input bit [argh_pkg::HASH_W-1:0] h);
      bit [7:0]                  s [16];
      bit [7:0]                  t [16];
      bit [7:0]                  acc;
      bit [argh_pkg::HASH_W-1:0] o;
      for (int i = 0; i < 16; i++) s[i] = h[8*i +: 8];
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[r + 4*c] = inv_sub_lut[s[r + 4*((c - r + 4) % 4)]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++) begin
               acc ^= gf_times(t[4*c + j], INV_MIX[(j - k + 4) % 4]);
            end
            o[8*(4*c + k) +: 8] = acc;
         end
      end
      return o;
   endfunction

   function automatic bit [argh_pkg::HASH_W-1:0] aes_dec_chain(
      input bit [argh_pkg::HASH_W-1:0] h);
      for (int k = 0; k < argh_pkg::ROUNDS_PER_BLOCK; k++) h = aes_dec_round(h);
      return h;
   endfunction

   // Advance the predicted state by one request. Returns 1 when the request
   // produces a result, which is then left in res.
   function automatic bit step_glyph_hash(
      input  bit                          cmd,
      input  bit                          first,
      input  bit [argh_pkg::LEN_W-1:0]    total,
      input  bit [argh_pkg::HALF_W-1:0]   dlo,
      input  bit [argh_pkg::HALF_W-1:0]   dhi,
      input  bit [argh_pkg::VBYTES_W-1:0] vbytes,
      input  bit                          last,
      input  bit [argh_pkg::TILE_W-1:0]   tile,
      output hash_result_type             res
   );
      bit [argh_pkg::HASH_W-1:0] h;
      bit [argh_pkg::HASH_W-1:0] keep;
      int unsigned               used;
      res = UNSET;
      if (cmd == argh_pkg::CMD_TILE) begin
         // The tile index fills all four 32-bit lanes; zero skips the rounds.
         h = kept_state;
         if (tile != '0) h = aes_dec_chain(h ^ {4{16'h0, tile}});
         res = '{h[63:0], h[127:64], 1'b1};
         return 1'b1;
      end
      used = (vbytes > 16) ? 16 : vbytes;
      keep = '0;
      for (int i = 0; i < 16; i++) begin
         if (i < used) keep[8*i +: 8] = 8'hff;
      end
      if (first) run_state = seed_state ^ {112'h0, total};
      run_state = aes_dec_chain(run_state ^ ({dhi, dlo} & keep));
      if (!last) return 1'b0;
      kept_state = run_state;
      res = '{run_state[63:0], run_state[127:64], 1'b0};
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: predict on every accepted request, score every accepted
   // result against the oldest expected hash.
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin : score_channels
      hash_result_type want;
      bit              produced;
      bit              took;
      if (!reset) begin
         took = 1'b0;
         // Seed writes only happen while the block is idle.
         if (csr_valid && csr_ready) begin
            took = 1'b1;
            case (csr_index)
               argh_pkg::CSR_SEED0: seed_state[31:0]   = csr_data;
               argh_pkg::CSR_SEED1: seed_state[63:32]  = csr_data;
               argh_pkg::CSR_SEED2: seed_state[95:64]  = csr_data;
               argh_pkg::CSR_SEED3: seed_state[127:96] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            took = 1'b1;
            if (req_command == argh_pkg::CMD_TILE) tile_count++;
            else chunk_count++;
            produced = step_glyph_hash(req_command, req_first_chunk, req_total_length,
                                       req_data_low, req_data_high, req_valid_bytes,
                                       req_last_chunk, req_tile_index, want);
            if (produced) pending_hashes.push_back(row_given ? row_want : want);
         end
         if (rsp_valid && !rsp_stall) begin
            took = 1'b1;
            if (pending_hashes.size() == 0) begin
               report_mismatch($sformatf("result %h_%h with no request pending",
                                         rsp_hash_high, rsp_hash_low));
            end else begin
               want = pending_hashes.pop_front();
               checked_count++;
               if (rsp_hash_low !== want.hash_low)
                  report_mismatch($sformatf("hash_low %h, expected %h",
                                            rsp_hash_low, want.hash_low));
               if (rsp_hash_high !== want.hash_high)
                  report_mismatch($sformatf("hash_high %h, expected %h",
                                            rsp_hash_high, want.hash_high));
               if (rsp_from_tile !== want.from_tile)
                  report_mismatch($sformatf("from_tile %b, expected %b",
                                            rsp_from_tile, want.from_tile));
            end
         end
         idle_cycles <= took ? 0 : idle_cycles + 1;
      end
   end

   // Receiver back-pressure: random stall bursts, each followed by a short free
   // stretch; lone free stretches may be long. No stalls in the final phase.
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         stall_left = 0;
         free_left = 0;
      end else if (stall_left == 0 && free_left == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 19);
            free_left = $urandom_range(1, 30);
         end else begin
            free_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 30);
         end
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (free_left != 0) free_left--;
      end
   end

   // The run is stuck if no channel moves for this long.
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Random sender gap: none when odds is zero, else a 1-in-odds chance of
   // a burst of idle time.
   function automatic int unsigned pick_gap(input int unsigned odds);
      if (odds == 0) return 0;
      return ($urandom_range(1, odds) == 1) ? $urandom_range(1, 19) : 0;
   endfunction

   // A request with every field random, byte counts up to 31 included.
   function automatic hash_request_type random_request();
      hash_request_type rq;
      rq.cmd    = 1'($urandom_range(0, 1));
      rq.first  = 1'($urandom_range(0, 1));
      rq.last   = 1'($urandom_range(0, 1));
      rq.vbytes = 5'($urandom_range(0, 31));
      rq.total  = 16'($urandom_range(0, 65535));
      rq.tile   = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
      rq.dlo    = {$urandom, $urandom};
      rq.dhi    = {$urandom, $urandom};
      rq.given  = 1'b0;
      rq.want   = UNSET;
      return rq;
   endfunction

   // Present one request after an optional gap and hold it until taken.
   // Called at a clock edge; returns at the edge where the request is taken,
   // having left req_valid untouched in that step.
   task automatic send_request(input hash_request_type rq, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= rq.cmd;
      req_first_chunk  <= rq.first;
      req_total_length <= rq.total;
      req_data_low     <= rq.dlo;
      req_data_high    <= rq.dhi;
      req_valid_bytes  <= rq.vbytes;
      req_last_chunk   <= rq.last;
      req_tile_index   <= rq.tile;
      row_given        <= rq.given;
      row_want         <= rq.want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_tile(input int unsigned odds);
      hash_request_type rq;
      rq = random_request();
      rq.cmd = argh_pkg::CMD_TILE;
      send_request(rq, pick_gap(odds));
   endtask

   // A string as the block expects it: a start chunk, full chunks, and a
   // last chunk holding the length modulo 16. Long lengths get a short run
   // of chunks, and now and then the last chunk is not marked last.
   task automatic send_string(input int unsigned odds);
      hash_request_type rq;
      int unsigned      len;
      int unsigned      full;
      bit               broken;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 80);
      full = len / 16;
      if (full > 6) full = $urandom_range(0, 6);
      broken = ($urandom_range(0, 9) == 0);
      for (int k = 0; k <= full; k++) begin
         rq = random_request();
         rq.cmd    = argh_pkg::CMD_CHUNK;
         rq.first  = (k == 0);
         rq.total  = 16'(len);
         rq.last   = (k == full) && !broken;
         rq.vbytes = (k == full) ? 5'(len % 16) : 5'd16;
         send_request(rq, pick_gap(odds));
      end
   endtask

   // Stop sending and wait for every expected hash, then let any chunk that
   // makes no result clear the pipeline.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four seed words back to back; the block must be idle.
   task automatic load_seeds(input bit [argh_pkg::HASH_W-1:0] words);
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= SEED_REGS[k];
         csr_data  <= words[32*k +: 32];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      bit [argh_pkg::HASH_W-1:0] words;
      int unsigned               odds;
      int unsigned               target;
      int unsigned               pick;
      int unsigned               gap_odds [PHASES];
      bit                        paused;

      for (int i = 0; i < 256; i++) inv_sub_lut[i] = inv_sub_byte(8'(i));
      seed_state = {argh_pkg::SEED3_RESET, argh_pkg::SEED2_RESET,
                    argh_pkg::SEED1_RESET, argh_pkg::SEED0_RESET};
      run_state  = '0;
      kept_state = '0;
      // Phase two has no sender gaps at all, and the last phase is quiet.
      gap_odds = '{3, 0, 5, 2, 4, 0};

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = argh_pkg::CMD_CHUNK;
      req_first_chunk  = 1'b0;
      req_total_length = '0;
      req_data_low     = '0;
      req_data_high    = '0;
      req_valid_bytes  = '0;
      req_last_chunk   = 1'b0;
      req_tile_index   = '0;
      row_given        = 1'b0;
      row_want         = UNSET;
      csr_valid        = 1'b0;
      csr_index        = argh_pkg::CSR_SEED0;
      csr_data         = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows run on the seed left by reset.
      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         send_request(DIRECTED_ROWS[n], pick_gap(3));
      end

      // Random phases: all-zero seed, all-one seed, then random seeds.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0:       words = '0;
            1:       words = '1;
            default: words = {$urandom, $urandom, $urandom, $urandom};
         endcase
         load_seeds(words);
         if (phase == PHASES - 1) quiet_tail <= 1'b1;
         odds = gap_odds[phase];
         target = items_sent + PHASE_ITEMS;
         paused = 1'b0;
         while (items_sent < target) begin
            // Halfway through, hold off until every expected hash is back.
            if (!paused && items_sent + PHASE_ITEMS / 2 >= target) begin
               drain_results();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
               send_string(odds);
               repeat ($urandom_range(0, 2)) send_tile(odds);
            end else if (pick < 16) begin
               send_tile(odds);
            end else begin
               send_request(random_request(), pick_gap(odds));
            end
         end
      end
      drain_results();

      $display("Sent %0d chunk and %0d tile requests under %0d seed settings.",
               chunk_count, tile_count, PHASES + 1);
      $display("Scored %0d hashes; %0d mismatches.", checked_count, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
hdl/argh_pkg.sv
hdl/aes_round_glyph_hash.sv
tb/sv/tb_top.sv
